### rtl/conv3_pkg.sv
// types, constants and helpers shared by the 3x3 convolution filter
// no dependencies; imported by every module of the block

package conv3_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // weighted sum: nine products of 8-bit unsigned by 8-bit signed
    localparam int SUM_W = 20;
    localparam int MAG_W = SUM_W - 1;

    // saturation limit of one color component
    localparam int PIX_MAX = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_KERNEL_UPPER = 3'd2,
        REG_KERNEL_LOWER = 3'd3,
        REG_SUM_OFFSET   = 3'd4,
        REG_SUM_DIVISOR  = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [10:0]        image_width;
        logic [10:0]        image_height;
        logic [47:0]        kernel_upper_rows;
        logic [23:0]        kernel_lower_row;
        logic signed [8:0]  sum_offset;
        logic [7:0]         sum_divisor;
    } cfg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       frame_end;
    } pixel_out_t;

    // one selected neighborhood: rgb[column][row], red in the low byte
    typedef struct packed {
        logic [2:0][2:0][23:0] rgb;
        logic [7:0]            alpha;
        logic                  frame_end;
    } win_entry_t;

    typedef enum logic {
        F_IDLE,
        F_RD
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_PREP,
        B_DIV,
        B_FIN
    } back_state_t;

    // signed kernel weight at a given row and column
    function automatic logic signed [7:0] kernel_weight(
        input logic [47:0] upper,
        input logic [23:0] lower,
        input logic [1:0]  row,
        input logic [1:0]  col
    );
        int unsigned sel;
        logic [7:0]  b;
        sel = 0;
        if (row < 2'd2)
        begin
            sel = 8 * (2 * 32'(col) + 32'(row));
            b = upper[sel +: 8];
        end
        else
        begin
            sel = 8 * 32'(col);
            b = lower[sel +: 8];
        end
        return signed'(b);
    endfunction

endpackage

### rtl/conv3_queue.sv
// two-entry queue of selected neighborhoods between front and back
// depends on conv3_pkg

module conv3_queue
    import conv3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  win_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output win_entry_t pop_entry
);

    win_entry_t  slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/conv3_front.sv
// front end: accepts pixels, keeps the line stores and the 3x3 window,
// tracks position and result count, pushes selected neighborhoods; uses conv3_pkg

module conv3_front
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH,
    parameter int MAX_HEIGHT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       pixel_valid,
    output logic       pixel_ready,
    input  pixel_in_t  pixel,
    output logic       push_valid,
    input  logic       push_ready,
    output win_entry_t push_entry
);

    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 3);
    localparam int POS_W = ROW_W + DIM_W;
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    front_state_t     state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] area_reg;
    logic [31:0]      win_reg [9];
    logic [31:0]      win_next [9];

    logic [31:0]      older_mem [MAX_WIDTH];
    logic [31:0]      newer_mem [MAX_WIDTH];
    logic [31:0]      top_rd_reg, mid_rd_reg;
    logic [31:0]      cur_reg;
    logic             in_frame_reg, row_one_reg, emit_reg;

    logic [31:0]      w_full, h_full;
    logic [DIM_W-1:0] w, wm1, xc, col_inc;
    logic [HGT_W-1:0] h;
    logic [POS_W-1:0] pos;
    logic             emit_now, in_frame, drop, start, commit, frame_end;
    logic [31:0]      top, bot;
    logic [CNT_W-1:0] count_inc;
    logic [1:0]       left_sel, right_sel;

    // frame size clamped to the supported range
    always_comb
    begin
        if (cfg.image_width == '0)
            w_full = 32'd1;
        else if (32'(cfg.image_width) > 32'(MAX_WIDTH))
            w_full = 32'(MAX_WIDTH);
        else
            w_full = 32'(cfg.image_width);
        if (cfg.image_height == '0)
            h_full = 32'd1;
        else if (32'(cfg.image_height) > 32'(MAX_HEIGHT))
            h_full = 32'(MAX_HEIGHT);
        else
            h_full = 32'(cfg.image_height);
        w   = w_full[DIM_W-1:0];
        h   = h_full[HGT_W-1:0];
        wm1 = w - DIM_W'(1);
    end

    // pixel count of the frame
    always_ff @(posedge clk)
    begin
        area_reg <= CNT_W'(w) * CNT_W'(h);
    end

    // classification at accept
    assign pixel_ready = (state_reg == F_IDLE);
    assign pos         = POS_W'(row_reg) * POS_W'(w) + POS_W'(col_reg);
    assign emit_now    = (pos >= POS_W'(w) + POS_W'(1));
    assign in_frame    = (row_reg < ROW_W'(h));
    assign drop        = pixel.mode && (row_reg == '0) && (col_reg == '0);
    assign start       = pixel_valid && pixel_ready && !drop;
    assign commit      = (state_reg == F_RD) && (!emit_reg || push_ready);

    // item capture
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (in_frame && !pixel.mode)
                cur_reg <= {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};
            else
                cur_reg <= '0;
            in_frame_reg <= in_frame;
            row_one_reg  <= (row_reg == ROW_W'(1));
            emit_reg     <= emit_now;
        end
    end

    // older line store
    always_ff @(posedge clk)
    begin
        if (start)
            top_rd_reg <= older_mem[col_reg];
        if (commit)
            older_mem[col_reg] <= mid_rd_reg;
    end

    // newer line store
    always_ff @(posedge clk)
    begin
        if (start)
            mid_rd_reg <= newer_mem[col_reg];
        if (commit)
            newer_mem[col_reg] <= cur_reg;
    end

    // window shift, position and count update
    always_comb
    begin
        top = row_one_reg ? mid_rd_reg : top_rd_reg;
        bot = in_frame_reg ? cur_reg : mid_rd_reg;
        for (int k = 0; k < 6; k++)
            win_next[k] = win_reg[k + 3];
        win_next[6] = top;
        win_next[7] = mid_rd_reg;
        win_next[8] = bot;

        col_inc  = DIM_W'(col_reg) + DIM_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= w)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end

        count_inc  = count_reg + CNT_W'(1);
        frame_end  = (count_inc >= area_reg);
        count_next = count_reg;
        if (emit_reg)
        begin
            count_next = count_inc;
            if (frame_end)
            begin
                count_next = '0;
                col_next   = '0;
                row_next   = '0;
            end
        end

        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_RD;
            end
            F_RD:
            begin
                if (commit)
                    state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    // edge clamping of the output column
    always_comb
    begin
        xc = (col_reg == '0) ? wm1 : DIM_W'(col_reg) - DIM_W'(1);
        if (xc > wm1)
            xc = wm1;
        left_sel  = (xc == '0) ? 2'd1 : 2'd0;
        right_sel = (xc >= wm1) ? 2'd1 : 2'd2;
    end

    // queue entry
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            push_entry.rgb[0][k] = win_next[32'(left_sel) * 3 + k][23:0];
            push_entry.rgb[1][k] = win_next[3 + k][23:0];
            push_entry.rgb[2][k] = win_next[32'(right_sel) * 3 + k][23:0];
        end
        push_entry.alpha     = win_next[4][31:24];
        push_entry.frame_end = frame_end;
    end

    assign push_valid = (state_reg == F_RD) && emit_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                count_reg <= count_next;
                for (int k = 0; k < 9; k++)
                    win_reg[k] <= win_next[k];
            end
        end
    end

endmodule

### rtl/conv3_back.sv
// back end: multiply-accumulate over nine taps, serial divide per channel,
// offset, saturation and the output register; uses conv3_pkg

module conv3_back
    import conv3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  win_entry_t pop_entry,
    output logic       result_valid,
    input  logic       result_ready,
    output pixel_out_t result
);

    localparam int STEP_W = $clog2(MAG_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);

    back_state_t              state_reg, state_next;
    win_entry_t               entry_reg;
    logic [1:0]               tap_j_reg, tap_k_reg;
    logic signed [SUM_W-1:0]  acc_reg [3];
    logic                     neg_reg [3];
    logic [MAG_W-1:0]         dvd_reg [3];
    logic [7:0]               rem_reg [3];
    logic [STEP_W-1:0]        step_reg;
    logic                     result_valid_reg;
    pixel_out_t               result_reg;

    logic signed [7:0]        weight;
    logic signed [16:0]       prod [3];
    logic [7:0]               divisor;
    logic [8:0]               rem_t [3];
    logic                     qbit [3];
    logic [SUM_W-1:0]         mag [3];
    logic signed [SUM_W-1:0]  quo [3];
    logic signed [SUM_W:0]    val [3];
    logic [7:0]               sat [3];
    logic                     load_out, last_tap;

    assign pop_ready    = (state_reg == B_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign divisor      = (cfg.sum_divisor == '0) ? 8'd1 : cfg.sum_divisor;
    assign last_tap     = (tap_j_reg == 2'd2) && (tap_k_reg == 2'd2);
    assign load_out     = (state_reg == B_FIN) && (!result_valid_reg || result_ready);

    // one tap product per channel
    always_comb
    begin
        weight = kernel_weight(cfg.kernel_upper_rows, cfg.kernel_lower_row,
                               tap_k_reg, tap_j_reg);
        for (int ch = 0; ch < 3; ch++)
            prod[ch] = $signed({1'b0, entry_reg.rgb[tap_j_reg][tap_k_reg][8*ch +: 8]})
                       * weight;
    end

    // divide step, sign fix, offset and saturation
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            mag[ch]   = acc_reg[ch] < 0 ? SUM_W'(-acc_reg[ch]) : SUM_W'(acc_reg[ch]);
            rem_t[ch] = {rem_reg[ch], dvd_reg[ch][MAG_W-1]};
            qbit[ch]  = (rem_t[ch] >= {1'b0, divisor});
            quo[ch]   = neg_reg[ch] ? -$signed({1'b0, dvd_reg[ch]})
                                    : $signed({1'b0, dvd_reg[ch]});
            val[ch]   = (SUM_W+1)'(quo[ch]) + (SUM_W+1)'(cfg.sum_offset);
            if (val[ch] < 0)
                sat[ch] = 8'd0;
            else if (val[ch] > (SUM_W+1)'(PIX_MAX))
                sat[ch] = 8'(PIX_MAX);
            else
                sat[ch] = val[ch][7:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                    state_next = B_MAC;
            end
            B_MAC:
            begin
                if (last_tap)
                    state_next = B_PREP;
            end
            B_PREP:
                state_next = B_DIV;
            B_DIV:
            begin
                if (step_reg == STEP_LAST)
                    state_next = B_FIN;
            end
            B_FIN:
            begin
                if (load_out)
                    state_next = B_IDLE;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                entry_reg <= pop_entry;
                tap_j_reg <= 2'd0;
                tap_k_reg <= 2'd0;
                for (int ch = 0; ch < 3; ch++)
                    acc_reg[ch] <= '0;
            end
            B_MAC:
            begin
                for (int ch = 0; ch < 3; ch++)
                    acc_reg[ch] <= acc_reg[ch] + SUM_W'(prod[ch]);
                if (tap_k_reg == 2'd2)
                begin
                    tap_k_reg <= 2'd0;
                    tap_j_reg <= tap_j_reg + 2'd1;
                end
                else
                begin
                    tap_k_reg <= tap_k_reg + 2'd1;
                end
            end
            B_PREP:
            begin
                step_reg <= '0;
                for (int ch = 0; ch < 3; ch++)
                begin
                    neg_reg[ch] <= acc_reg[ch] < 0;
                    dvd_reg[ch] <= mag[ch][MAG_W-1:0];
                    rem_reg[ch] <= '0;
                end
            end
            B_DIV:
            begin
                step_reg <= step_reg + STEP_W'(1);
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (qbit[ch])
                        rem_reg[ch] <= 8'(rem_t[ch] - {1'b0, divisor});
                    else
                        rem_reg[ch] <= rem_t[ch][7:0];
                    dvd_reg[ch] <= {dvd_reg[ch][MAG_W-2:0], qbit[ch]};
                end
            end
            B_FIN:
            begin
                if (load_out)
                begin
                    result_reg.red_out   <= sat[0];
                    result_reg.green_out <= sat[1];
                    result_reg.blue_out  <= sat[2];
                    result_reg.alpha_out <= entry_reg.alpha;
                    result_reg.frame_end <= entry_reg.frame_end;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_start_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && pop_valid) |=> (state_reg == B_MAC))
        else $error("back end did not start accumulating a popped entry");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV && step_reg == STEP_LAST) |=> (state_reg == B_FIN))
        else $error("divider ran past its last step");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == B_FIN))
        else $error("result raised outside the final state");
`endif

endmodule

### rtl/convolution_3x3_rgb_filter_top.sv
// 3x3 convolution filter over an RGBA pixel stream, top level
// depends on conv3_pkg, conv3_front, conv3_queue and conv3_back

// Pixels of one frame enter in raster order; a result for a pixel appears
// image_width+1 items later, so image_width+1 drain items flush a frame.
// The front end takes one item at a time (line store read, then write-back
// and window shift). Items that produce a result are then bound by the back
// end: 9 multiply-accumulate steps, a setup step, 19 serial divider steps
// and an output step that waits for result_ready. A two-entry queue lets
// the front keep taking items while the back works.
// The line stores need no clearing after reset. The config channel is always
// ready, but registers must only be written while no request is in flight,
// since the back end reads the kernel, offset and divisor while it works.

module convolution_3x3_rgb_filter_top
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  pixel_in_t             pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pixel_out_t            result
);

    cfg_t       cfg_reg;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    win_entry_t push_entry, pop_entry;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width       <= 11'd1024;
            cfg_reg.image_height      <= 11'd1024;
            cfg_reg.kernel_upper_rows <= '0;
            cfg_reg.kernel_lower_row  <= '0;
            cfg_reg.sum_offset        <= '0;
            cfg_reg.sum_divisor       <= 8'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_reg.image_width       <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height      <= cfg_data[10:0];
                REG_KERNEL_UPPER: cfg_reg.kernel_upper_rows <= cfg_data[47:0];
                REG_KERNEL_LOWER: cfg_reg.kernel_lower_row  <= cfg_data[23:0];
                REG_SUM_OFFSET:   cfg_reg.sum_offset        <= signed'(cfg_data[8:0]);
                REG_SUM_DIVISOR:  cfg_reg.sum_divisor       <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // pixel intake and window
    conv3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    // decoupling queue
    conv3_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // arithmetic and output
    conv3_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
